// ===== rtl/core/forth_data_stack_engine_macros.svh =====
// Assertion macros for the Forth data stack engine.
`ifndef FORTH_DATA_STACK_ENGINE_MACROS_SVH
`define FORTH_DATA_STACK_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FDS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fds: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FDS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fds: next-cycle check failed");

`endif

// ===== rtl/core/fds_pkg.sv =====
// Shared constants, widths and operation codes of the Forth data stack engine.
`default_nettype none
package fds_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int DATA_WIDTH  = 32;

   localparam int ADDR_W  = $clog2(STACK_DEPTH);
   localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W   = ((DATA_WIDTH > CNT_W) ? DATA_WIDTH : CNT_W) + 2;

   localparam int OP_W    = 3;
   localparam int PUSH_W  = 32;
   localparam int TOP_W   = 32;
   localparam int DEPTH_W = 9;
   localparam int FAULT_W = 2;

   localparam logic [OP_W-1:0] OP_PUSH       = 3'd0;
   localparam logic [OP_W-1:0] OP_DROP       = 3'd1;
   localparam logic [OP_W-1:0] OP_DROP_N     = 3'd2;
   localparam logic [OP_W-1:0] OP_DUP        = 3'd3;
   localparam logic [OP_W-1:0] OP_N_DUP      = 3'd4;
   localparam logic [OP_W-1:0] OP_PICK       = 3'd5;
   localparam logic [OP_W-1:0] OP_SWAP       = 3'd6;
   localparam logic [OP_W-1:0] OP_PUSH_DEPTH = 3'd7;

   localparam logic [FAULT_W-1:0] FLT_OK    = 2'd0;
   localparam logic [FAULT_W-1:0] FLT_UNDER = 2'd1;
   localparam logic [FAULT_W-1:0] FLT_OVER  = 2'd2;
   localparam logic [FAULT_W-1:0] FLT_NEG   = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/core/fds_req_if.sv =====
// Request channel: operation and push value with valid/ready.
`default_nettype none
interface fds_req_if
   import fds_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [PUSH_W-1:0] push_value;

   modport source (output valid, output op, output push_value, input ready);
   modport sink   (input valid, input op, input push_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fds_rsp_if.sv =====
// Response channel: top of stack, depth and fault code with valid/ready.
`default_nettype none
interface fds_rsp_if
   import fds_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [TOP_W-1:0] top_value;
   logic [DEPTH_W-1:0]      stack_depth;
   logic [FAULT_W-1:0]      fault;

   modport source (output valid, output top_value, output stack_depth, output fault,
                   input ready);
   modport sink   (input valid, input top_value, input stack_depth, input fault,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/forth_data_stack_engine.sv =====
// Forth data stack engine: stack in one RAM, top of stack cached in a register.
//
// Usage: one beat on req_bus (op, push_value) yields one beat on rsp_bus
// (top_value, stack_depth, fault); responses come back in request order.
// A faulting request leaves the stack untouched and reports the current
// top and depth.
// Path from request acceptance to a loaded response register, by op:
//   push, push_depth, dup and any faulting request: loaded on acceptance
//   drop, drop_n, pick, n_dup with a count of zero: after the RAM read state
//   swap: after the RAM read state and the swap write state
//   n_dup with count n: after the RAM read state and the fill state (one RAM write per copy)
// Push, push_depth, dup and faulting requests sustain one beat per cycle while
// rsp_bus.ready is high; others hold req_bus.ready low until done. The rate is set
// by the single RAM write port and the registered RAM read in read-modify-write.
// A finished response waits in an output register; a new request is taken
// in the same cycle the waiting response is taken. While rsp_bus.ready is
// low with a response held, no request is accepted.
// Reset (synchronous, active high) empties the stack and drops any pending
// response; the RAM is not cleared, no entry above the depth is ever used.
`default_nettype none
`include "forth_data_stack_engine_macros.svh"
module forth_data_stack_engine
   import fds_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   fds_req_if.sink   req_bus,
   fds_rsp_if.source rsp_bus
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_SWAP = 2'd2;
   localparam logic [1:0] S_FILL = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_WIDTH-1:0] top_ff, top_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [ADDR_W-1:0]     ptr_ff, ptr_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TOP_W-1:0]      rsp_top_ff, rsp_top_in;
   logic [DEPTH_W-1:0]    rsp_depth_ff, rsp_depth_in;
   logic [FAULT_W-1:0]    rsp_fault_ff, rsp_fault_in;

   logic                  accept;
   logic                  rsp_load;
   logic [FAULT_W-1:0]    load_fault;
   logic [FAULT_W-1:0]    fault_code;
   logic                  is_cnt_op;
   logic                  is_empty;
   logic                  is_full;
   logic                  lt_two;
   logic [CMP_W-1:0]      d_wide;
   logic [CMP_W-1:0]      n_wide;
   logic [CNT_W-1:0]      n_cnt;
   logic [CNT_W-1:0]      cnt_m1;
   logic [CNT_W-1:0]      cnt_m2;
   logic [CNT_W-1:0]      cnt_m2n;
   logic [DATA_WIDTH-1:0] pv_ext;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   fds_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   assign is_cnt_op = (req_bus.op == OP_DROP_N) || (req_bus.op == OP_N_DUP) ||
                      (req_bus.op == OP_PICK);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(STACK_DEPTH));
   assign lt_two    = (count_ff < CNT_W'(2));
   assign d_wide    = CMP_W'(count_ff);
   assign n_wide    = CMP_W'(top_ff);
   assign n_cnt     = CNT_W'(top_ff);
   assign cnt_m1    = count_ff - CNT_W'(1);
   assign cnt_m2    = count_ff - CNT_W'(2);
   assign cnt_m2n   = cnt_m2 - n_cnt;
   assign pv_ext    = DATA_WIDTH'(req_bus.push_value);

   assign rd_addr = ((req_bus.op == OP_DROP_N) || (req_bus.op == OP_PICK)) ?
                    cnt_m2n[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];

   always_comb begin
      fault_code = FLT_OK;
      if (is_cnt_op && is_empty) begin
         fault_code = FLT_UNDER;
      end else if (is_cnt_op && top_ff[DATA_WIDTH-1]) begin
         fault_code = FLT_NEG;
      end else begin
         unique case (req_bus.op)
            OP_PUSH, OP_PUSH_DEPTH: begin
               if (is_full) fault_code = FLT_OVER;
            end
            OP_DROP: begin
               if (is_empty) fault_code = FLT_UNDER;
            end
            OP_DROP_N: begin
               if (n_wide >= d_wide) fault_code = FLT_UNDER;
            end
            OP_DUP: begin
               if (is_empty) fault_code = FLT_UNDER;
               else if (is_full) fault_code = FLT_OVER;
            end
            OP_N_DUP: begin
               if (lt_two) fault_code = FLT_UNDER;
               else if (n_wide > CMP_W'(STACK_DEPTH) - d_wide + CMP_W'(1))
                  fault_code = FLT_OVER;
            end
            OP_PICK: begin
               if (lt_two || (n_wide + CMP_W'(2) > d_wide)) fault_code = FLT_UNDER;
            end
            OP_SWAP: begin
               if (lt_two) fault_code = FLT_UNDER;
            end
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      top_in     = top_ff;
      op_in      = op_ff;
      n_in       = n_ff;
      val_in     = val_ff;
      ptr_in     = ptr_ff;
      rem_in     = rem_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[ADDR_W-1:0];
      wr_data    = top_ff;
      rsp_load   = 1'b0;
      load_fault = FLT_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_bus.op;
               n_in  = n_cnt;
               if (fault_code != FLT_OK) begin
                  rsp_load   = 1'b1;
                  load_fault = fault_code;
               end else begin
                  unique case (req_bus.op)
                     OP_PUSH, OP_PUSH_DEPTH, OP_DUP: begin
                        wr_en    = 1'b1;
                        wr_data  = (req_bus.op == OP_PUSH)       ? pv_ext :
                                   (req_bus.op == OP_PUSH_DEPTH) ? DATA_WIDTH'(count_ff) :
                                                                   top_ff;
                        top_in   = wr_data;
                        count_in = count_ff + CNT_W'(1);
                        rsp_load = 1'b1;
                     end
                     default: begin
                        state_in = S_RD;
                     end
                  endcase
               end
            end
         end
         S_RD: begin
            unique case (op_ff)
               OP_DROP: begin
                  count_in = cnt_m1;
                  top_in   = rd_data;
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
               end
               OP_DROP_N: begin
                  count_in = cnt_m1 - n_ff;
                  top_in   = rd_data;
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
               end
               OP_N_DUP: begin
                  top_in = rd_data;
                  val_in = rd_data;
                  if (n_ff == '0) begin
                     count_in = cnt_m1;
                     rsp_load = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     ptr_in   = cnt_m1[ADDR_W-1:0];
                     rem_in   = n_ff;
                     state_in = S_FILL;
                  end
               end
               OP_PICK: begin
                  wr_en    = 1'b1;
                  wr_addr  = cnt_m1[ADDR_W-1:0];
                  wr_data  = rd_data;
                  top_in   = rd_data;
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
               end
               OP_SWAP: begin
                  wr_en    = 1'b1;
                  wr_addr  = cnt_m1[ADDR_W-1:0];
                  wr_data  = rd_data;
                  top_in   = rd_data;
                  val_in   = top_ff;
                  state_in = S_SWAP;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SWAP: begin
            wr_en    = 1'b1;
            wr_addr  = cnt_m2[ADDR_W-1:0];
            wr_data  = val_ff;
            rsp_load = 1'b1;
            state_in = S_IDLE;
         end
         S_FILL: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = val_ff;
            ptr_in  = ptr_ff + ADDR_W'(1);
            rem_in  = rem_ff - CNT_W'(1);
            if (rem_ff == CNT_W'(1)) begin
               count_in = cnt_m1 + n_ff;
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_top_in   = rsp_top_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (rsp_load) begin
         rsp_top_in   = (count_in != '0) ? TOP_W'(top_in) : '0;
         rsp_depth_in = DEPTH_W'(count_in);
         rsp_fault_in = load_fault;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff       <= top_in;
      op_ff        <= op_in;
      n_ff         <= n_in;
      val_ff       <= val_in;
      ptr_ff       <= ptr_in;
      rem_ff       <= rem_in;
      rsp_top_ff   <= rsp_top_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.top_value   = rsp_top_ff;
   assign rsp_bus.stack_depth = rsp_depth_ff;
   assign rsp_bus.fault       = rsp_fault_ff;

   `FDS_ASSERT_IMP(a_depth_bound, clock, reset, 1'b1, count_ff <= CNT_W'(STACK_DEPTH))
   `FDS_ASSERT_NXT(a_fault_keeps_depth, clock, reset, accept && (fault_code != FLT_OK), $stable(count_ff))
   `FDS_ASSERT_IMP(a_fill_in_range, clock, reset, state_ff == S_FILL, CNT_W'(ptr_ff) < cnt_m1 + n_ff)
   `FDS_ASSERT_NXT(a_rsp_depth_match, clock, reset, rsp_load, rsp_depth_ff == DEPTH_W'(count_ff))

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the Forth data stack engine: directed table, then random traffic.
`timescale 1ns / 1ps
module testbench
   import fds_pkg::*;
();

   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_DIRECTED = 27;

   typedef struct packed {
      logic [TOP_W-1:0]   top;
      logic [DEPTH_W-1:0] depth;
      logic [FAULT_W-1:0] fault;
   } stack_result_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [PUSH_W-1:0] value;
   } stack_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [PUSH_W-1:0] value;
      logic              pinned;
      stack_result_type  want;
   } directed_row_type;

   typedef enum int {ALWAYS_READY, MOSTLY_READY, PERIODIC_STALL, MOSTLY_STALLED} stall_mode_type;

   logic clock = 1'b0;
   logic reset;

   fds_req_if req_bus ();
   fds_rsp_if rsp_bus ();

   forth_data_stack_engine i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
   int unsigned           stack_count = 0;
   stack_result_type      pending_results [$];
   stack_cmd_type         planned_cmds [$];
   logic                  pin_flag;
   stack_result_type      pin_result;
   int unsigned           accept_count = 0;
   int unsigned           response_count = 0;
   int unsigned           fail_count = 0;
   int unsigned           cycle_count = 0;
   int unsigned           burst_left = 0;
   int unsigned           deepest = 0;
   int unsigned           op_hits [8] = '{default: 0};
   int unsigned           fault_hits [4] = '{default: 0};
   stall_mode_type        stall_mode;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{OP_DROP,       32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd0,   FLT_UNDER}},
      '{OP_DROP_N,     32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd0,   FLT_UNDER}},
      '{OP_N_DUP,      32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd0,   FLT_UNDER}},
      '{OP_PICK,       32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd0,   FLT_UNDER}},
      '{OP_SWAP,       32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd0,   FLT_UNDER}},
      '{OP_PUSH,       32'h7fff_ffff, 1'b1, '{32'h7fff_ffff, 9'd1,   FLT_OK}},
      '{OP_SWAP,       32'hffff_ffff, 1'b1, '{32'h7fff_ffff, 9'd1,   FLT_UNDER}},
      '{OP_N_DUP,      32'h0000_0000, 1'b1, '{32'h7fff_ffff, 9'd1,   FLT_UNDER}},
      '{OP_PUSH,       32'h8000_0000, 1'b1, '{32'h8000_0000, 9'd2,   FLT_OK}},
      '{OP_DROP_N,     32'h0000_0000, 1'b1, '{32'h8000_0000, 9'd2,   FLT_NEG}},
      '{OP_PICK,       32'h0000_0000, 1'b1, '{32'h8000_0000, 9'd2,   FLT_NEG}},
      '{OP_N_DUP,      32'h0000_0000, 1'b1, '{32'h8000_0000, 9'd2,   FLT_NEG}},
      '{OP_PUSH_DEPTH, 32'h1234_5678, 1'b1, '{32'h0000_0002, 9'd3,   FLT_OK}},
      '{OP_PICK,       32'h0000_0000, 1'b1, '{32'h0000_0002, 9'd3,   FLT_UNDER}},
      '{OP_DROP,       32'h0000_0000, 1'b1, '{32'h8000_0000, 9'd2,   FLT_OK}},
      '{OP_PUSH,       32'h0000_0001, 1'b0, '{32'h0000_0000, 9'd0,   FLT_OK}},
      '{OP_PICK,       32'h0000_0000, 1'b0, '{32'h0000_0000, 9'd0,   FLT_OK}},
      '{OP_SWAP,       32'h0000_0000, 1'b0, '{32'h0000_0000, 9'd0,   FLT_OK}},
      '{OP_PUSH,       32'h0000_00fe, 1'b0, '{32'h0000_0000, 9'd0,   FLT_OK}},
      '{OP_PUSH,       32'h0000_00ff, 1'b0, '{32'h0000_0000, 9'd0,   FLT_OK}},
      '{OP_N_DUP,      32'h0000_0000, 1'b1, '{32'h0000_00ff, 9'd5,   FLT_OVER}},
      '{OP_DROP,       32'h0000_0000, 1'b0, '{32'h0000_0000, 9'd0,   FLT_OK}},
      '{OP_PUSH,       32'h0000_00fc, 1'b0, '{32'h0000_0000, 9'd0,   FLT_OK}},
      '{OP_N_DUP,      32'h0000_0000, 1'b1, '{32'h0000_00fe, 9'd256, FLT_OK}},
      '{OP_PUSH,       32'h0000_0005, 1'b1, '{32'h0000_00fe, 9'd256, FLT_OVER}},
      '{OP_PUSH_DEPTH, 32'h0000_0000, 1'b1, '{32'h0000_00fe, 9'd256, FLT_OVER}},
      '{OP_DROP_N,     32'h0000_0000, 1'b1, '{32'h7fff_ffff, 9'd1,   FLT_OK}}
   };

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("forth_data_stack_engine regression: fail");
         $finish;
      end
   end

   function automatic void report_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("ERROR: %s", what);
   endfunction

   function automatic stack_result_type apply_stack_op(input logic [OP_W-1:0] op,
                                                      input logic [PUSH_W-1:0] value);
      longint                d;
      longint                n;
      longint                k;
      logic [DATA_WIDTH-1:0] held;
      logic [FAULT_W-1:0]    flt;
      stack_result_type      r;
      d = stack_count;
      n = 0;
      flt = FLT_OK;
      if (op == OP_DROP_N || op == OP_N_DUP || op == OP_PICK) begin
         if (d == 0) flt = FLT_UNDER;
         else if (stack_mem[d-1][DATA_WIDTH-1]) flt = FLT_NEG;
         else n = longint'(stack_mem[d-1]);
      end
      if (flt == FLT_OK) begin
         case (op)
            OP_PUSH, OP_PUSH_DEPTH: begin
               if (d >= STACK_DEPTH) flt = FLT_OVER;
               else begin
                  stack_mem[d] = (op == OP_PUSH) ? value : DATA_WIDTH'(d);
                  stack_count = 32'(d + 1);
               end
            end
            OP_DROP: begin
               if (d == 0) flt = FLT_UNDER;
               else stack_count = 32'(d - 1);
            end
            OP_DROP_N: begin
               if (n >= d) flt = FLT_UNDER;
               else stack_count = 32'(d - 1 - n);
            end
            OP_DUP: begin
               if (d == 0) flt = FLT_UNDER;
               else if (d >= STACK_DEPTH) flt = FLT_OVER;
               else begin
                  stack_mem[d] = stack_mem[d-1];
                  stack_count = 32'(d + 1);
               end
            end
            OP_N_DUP: begin
               if (d < 2) flt = FLT_UNDER;
               else if (n > STACK_DEPTH - (d - 1)) flt = FLT_OVER;
               else begin
                  held = stack_mem[d-2];
                  for (k = 0; k < n; k++) stack_mem[d-1+k] = held;
                  stack_count = 32'(d - 1 + n);
               end
            end
            OP_PICK: begin
               if (d < 2 || n > d - 2) flt = FLT_UNDER;
               else stack_mem[d-1] = stack_mem[d-2-n];
            end
            default: begin
               if (d < 2) flt = FLT_UNDER;
               else begin
                  held = stack_mem[d-1];
                  stack_mem[d-1] = stack_mem[d-2];
                  stack_mem[d-2] = held;
               end
            end
         endcase
      end
      r.top = (stack_count > 0) ? stack_mem[stack_count-1][TOP_W-1:0] : '0;
      r.depth = DEPTH_W'(stack_count);
      r.fault = flt;
      return r;
   endfunction

   function automatic void plan_cmd(input logic [OP_W-1:0] op, input logic [PUSH_W-1:0] value);
      stack_cmd_type c;
      c.op = op;
      c.value = value;
      planned_cmds.push_back(c);
   endfunction

   function automatic stack_cmd_type next_random_cmd();
      stack_cmd_type   c;
      int unsigned     d;
      int unsigned     roll;
      int unsigned     n;
      logic            corner;
      logic [OP_W-1:0] count_op;
      if (planned_cmds.size() > 0) return planned_cmds.pop_front();
      d = stack_count;
      roll = $urandom_range(0, 99);
      c.op = OP_PUSH;
      c.value = $urandom;
      if (roll < 8) begin
         c.op = OP_W'($urandom_range(0, 7));
      end else if (roll < 11 && d >= 100 && d <= 250) begin
         // fill to the top with copies of a count, bounce off the top, then unwind
         c.value = $urandom_range(1, 60);
         plan_cmd(OP_PUSH, PUSH_W'(STACK_DEPTH - 1 - d));
         plan_cmd(OP_N_DUP, $urandom);
         plan_cmd(OP_PUSH, $urandom);
         plan_cmd(OP_DUP, $urandom);
         plan_cmd(OP_PUSH_DEPTH, $urandom);
         plan_cmd(OP_DROP_N, $urandom);
      end else if (roll < 45) begin
         case ($urandom_range(0, 2))
            0: count_op = OP_DROP_N;
            1: count_op = OP_N_DUP;
            default: count_op = OP_PICK;
         endcase
         if (d > 200) count_op = OP_DROP_N;
         corner = ($urandom_range(0, 7) == 0);
         case (count_op)
            OP_DROP_N: begin
               if (corner) n = d + $urandom_range(0, 1);
               else n = $urandom_range(0, (d < 6) ? d : 6);
            end
            OP_N_DUP: begin
               if (corner && d >= 180) n = STACK_DEPTH - d + $urandom_range(0, 1);
               else if (corner) n = STACK_DEPTH + 1 - d;
               else n = $urandom_range(0, 4);
            end
            default: begin
               if (corner || d == 0) n = d;
               else n = $urandom_range(0, d - 1);
            end
         endcase
         c.value = n;
         plan_cmd(count_op, $urandom);
      end else if (roll < 70 || (d < 2 && roll < 85)) begin
         case ($urandom_range(0, 3))
            0: c.value = $urandom;
            1: c.value = $urandom_range(0, 15);
            2: begin
               case ($urandom_range(0, 3))
                  0: c.value = 32'h7fff_ffff;
                  1: c.value = 32'h8000_0000;
                  2: c.value = '0;
                  default: c.value = '1;
               endcase
            end
            default: c.value = 0 - $urandom_range(1, 8);
         endcase
      end else begin
         case ($urandom_range(0, 3))
            0: c.op = OP_DUP;
            1: c.op = OP_DROP;
            2: c.op = OP_SWAP;
            default: c.op = OP_PUSH_DEPTH;
         endcase
         if (d > 180 && $urandom_range(0, 1) == 0) c.op = OP_DROP;
      end
      return c;
   endfunction

   // after an optional random gap, hold one beat on the request channel until it is taken
   task automatic send_item(input logic [OP_W-1:0] op, input logic [PUSH_W-1:0] value,
                            input logic pinned, input stack_result_type want);
      int unsigned gap;
      int unsigned seen;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      seen = accept_count;
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.push_value <= value;
      pin_flag <= pinned;
      pin_result <= want;
      do @(negedge clock); while (accept_count == seen);
   endtask

   always @(posedge clock) begin : monitor
      stack_result_type got;
      stack_result_type want;
      stack_result_type predicted;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.top = rsp_bus.top_value;
            got.depth = rsp_bus.stack_depth;
            got.fault = rsp_bus.fault;
            response_count++;
            fault_hits[got.fault]++;
            if (pending_results.size() == 0) begin
               report_failure($sformatf("beat %0d with none pending: top %h depth %0d fault %0d",
                                        response_count, got.top, got.depth, got.fault));
            end else begin
               want = pending_results.pop_front();
               if (got.top !== want.top || got.depth !== want.depth ||
                   got.fault !== want.fault)
                  report_failure($sformatf("beat %0d: expected top %h depth %0d fault %0d, %s",
                     response_count, want.top, want.depth, want.fault,
                     $sformatf("got top %h depth %0d fault %0d",
                               got.top, got.depth, got.fault)));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predicted = apply_stack_op(req_bus.op, req_bus.push_value);
            pending_results.push_back(pin_flag ? pin_result : predicted);
            op_hits[req_bus.op]++;
            if (stack_count > deepest) deepest = stack_count;
            accept_count++;
         end
      end
   end

   initial begin : receiver
      int unsigned phase;
      phase = 0;
      stall_mode = ALWAYS_READY;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         phase++;
         if (phase % 40 == 0) stall_mode = stall_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            ALWAYS_READY:   rsp_bus.ready <= 1'b1;
            MOSTLY_READY:   rsp_bus.ready <= ($urandom_range(0, 9) < 7);
            PERIODIC_STALL: rsp_bus.ready <= (phase % 5 >= 2);
            default:        rsp_bus.ready <= ($urandom_range(0, 9) < 2);
         endcase
      end
   end

   initial begin : stimulus
      stack_cmd_type    cmd;
      stack_result_type none;
      int unsigned      idx;
      none = '0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_PUSH;
      req_bus.push_value = '0;
      pin_flag = 1'b0;
      pin_result = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (idx = 0; idx < NUM_DIRECTED; idx++)
         send_item(directed_rows[idx].op, directed_rows[idx].value,
                   directed_rows[idx].pinned, directed_rows[idx].want);

      idx = 0;
      while (idx < RANDOM_ITEMS || planned_cmds.size() > 0) begin
         cmd = next_random_cmd();
         send_item(cmd.op, cmd.value, 1'b0, none);
         idx++;
      end
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $write("covered %0d requests: push %0d drop %0d drop_n %0d dup %0d",
             accept_count, op_hits[OP_PUSH], op_hits[OP_DROP], op_hits[OP_DROP_N],
             op_hits[OP_DUP]);
      $display(" n_dup %0d pick %0d swap %0d push_depth %0d",
               op_hits[OP_N_DUP], op_hits[OP_PICK], op_hits[OP_SWAP],
               op_hits[OP_PUSH_DEPTH]);
      $write("%0d responses: ok %0d underflow %0d overflow %0d",
             response_count, fault_hits[FLT_OK], fault_hits[FLT_UNDER], fault_hits[FLT_OVER]);
      $display(" negative count %0d, deepest stack %0d", fault_hits[FLT_NEG], deepest);
      if (fail_count == 0) begin
         $display("forth_data_stack_engine regression: pass");
      end else begin
         $display("forth_data_stack_engine regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/fds_pkg.sv
rtl/core/fds_req_if.sv
rtl/core/fds_rsp_if.sv
rtl/core/fds_ram.sv
rtl/core/forth_data_stack_engine.sv
test/testbench.sv
